[hw/rtl/ffap_pkg.sv]
// Shared types, constants and codes for the first-fit pool allocator.
`default_nettype none

package ffap_pkg;

  localparam int ADDR_W           = 36;
  localparam int LEN_W            = 37;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 37;
  localparam int DEF_MAX_SEGMENTS = 64;

  localparam logic [LEN_W-1:0] POOL_SIZE_RST = 37'd1073741824;
  localparam logic [LEN_W-1:0] MIN_SPLIT_RST = 37'd1024;
  localparam logic [LEN_W-1:0] GRANULE_ROUND = 37'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPLIT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [LEN_W-1:0] res;
    logic             ge;
    logic             zero;
  } alu_res_t;

  typedef struct packed {
    logic             free;
    logic [LEN_W-1:0] len;
    logic [ADDR_W-1:0] off;
  } seg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_SPLIT,
    S_OFFS,
    S_SHUP,
    S_PUT,
    S_FNEXT,
    S_ADD2,
    S_SHDN,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/ffap_if.sv]
// Request and response channel interfaces of the pool allocator.
`default_nettype none

interface ffap_req_if import ffap_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] request_size;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, mode, request_size, block_address, input ready);
  modport sink   (input valid, mode, request_size, block_address, output ready);
endinterface

interface ffap_rsp_if import ffap_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] granted_address;
  logic [1:0]        status;

  modport source (output valid, granted_address, status, input ready);
  modport sink   (input valid, granted_address, status, output ready);
endinterface

`default_nettype wire

[hw/rtl/ffap_seg_mem.sv]
// Segment table memory: one write port, one registered read port.
`default_nettype none

module ffap_seg_mem import ffap_pkg::*; #(
  parameter int DEPTH = DEF_MAX_SEGMENTS,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  seg_t             wdata,
  input  logic [IDX_W-1:0] raddr,
  output seg_t             rdata
);

  seg_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/ffap_alu.sv]
// Shared add/subtract unit with compare flags.
`default_nettype none

module ffap_alu import ffap_pkg::*; (
  input  alu_op_t          op,
  input  logic [LEN_W-1:0] a,
  input  logic [LEN_W-1:0] b,
  output alu_res_t         result
);

  logic [LEN_W:0] wide;

  always_comb begin
    unique case (op)
      ALU_ADD: wide = {1'b0, a} + {1'b0, b};
      ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      default: wide = '0;
    endcase
    result.res  = wide[LEN_W-1:0];
    result.ge   = ~wide[LEN_W];
    result.zero = (wide[LEN_W-1:0] == '0);
  end

endmodule

`default_nettype wire

[hw/rtl/ffap_seq.sv]
// Sequencer: table scan, split, merge and shift steps around the shared ALU.
`default_nettype none

module ffap_seq import ffap_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  localparam int IDX_W = $clog2(MAX_SEGMENTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             reinit,
  input  logic [LEN_W-1:0] pool_size,
  input  logic [LEN_W-1:0] min_split,
  ffap_req_if.sink         req,
  ffap_rsp_if.source       rsp,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output seg_t             mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  seg_t             mem_rdata,
  output alu_op_t          alu_op,
  output logic [LEN_W-1:0] alu_a,
  output logic [LEN_W-1:0] alu_b,
  input  alu_res_t         alu_res
);

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  sh_r, sh_nxt;
  logic              mode_r, mode_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0]  need_r, need_nxt;
  logic [LEN_W-1:0]  rest_r, rest_nxt;
  logic [LEN_W-1:0]  acc_r, acc_nxt;
  logic [LEN_W-1:0]  nxt_len_r, nxt_len_nxt;
  logic              nf_r, nf_nxt;
  logic [1:0]        ers_r, ers_nxt;
  seg_t              seg_r, seg_nxt;
  seg_t              prev_r, prev_nxt;
  seg_t              new_r, new_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic              accept;
  logic              is_alloc;
  logic              scan_hit;
  logic              scan_last;
  logic              split_ok;
  logic              pf;
  logic [1:0]        ers;
  logic [IDX_W-1:0]  base;
  logic [SUM_W-1:0]  pos_w, cnt_w, k0, src0;
  logic              shdn_more;
  logic              shup_done;
  logic              offs_nomove;
  logic              out_free;

  assign req.ready = (state_r == S_IDLE) && !reinit;
  assign accept    = req.valid && req.ready;
  assign is_alloc  = (mode_r == MODE_ALLOC);

  assign pos_w     = SUM_W'(pos_r);
  assign cnt_w     = SUM_W'(count_r);
  assign scan_hit  = is_alloc ? (mem_rdata.free && alu_res.ge) : alu_res.zero;
  assign scan_last = (SUM_W'(cur_r) + SUM_W'(1)) == cnt_w;
  assign split_ok  = alu_res.ge && !alu_res.zero && (count_r < CNT_MAX);

  assign pf        = (pos_r != '0) && prev_r.free;
  assign ers       = {1'b0, pf} + {1'b0, nf_r};
  assign base      = pf ? (pos_r - IDX_W'(1)) : pos_r;
  assign k0        = SUM_W'(base) + SUM_W'(1);
  assign src0      = k0 + SUM_W'(ers);
  assign shdn_more = (SUM_W'(sh_r) + SUM_W'(ers_r) + SUM_W'(1)) < cnt_w;
  assign shup_done = SUM_W'(sh_r) == (pos_w + SUM_W'(2));
  assign offs_nomove = cnt_w == (pos_w + SUM_W'(1));
  assign out_free  = !out_valid_r || rsp.ready;

  assign rsp.valid           = out_valid_r;
  assign rsp.status          = out_status_r;
  assign rsp.granted_address = out_addr_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_hit) begin
          if (is_alloc) begin
            state_nxt = S_SPLIT;
          end else begin
            state_nxt = mem_rdata.free ? S_OUT : S_FNEXT;
          end
        end else if (scan_last) begin
          state_nxt = S_OUT;
        end
      end
      S_SPLIT: state_nxt = split_ok ? S_OFFS : S_OUT;
      S_OFFS:  state_nxt = offs_nomove ? S_PUT : S_SHUP;
      S_SHUP:  if (shup_done) state_nxt = S_PUT;
      S_PUT:   state_nxt = S_OUT;
      S_FNEXT: state_nxt = S_ADD2;
      S_ADD2:  state_nxt = (src0 < cnt_w) ? S_SHDN : S_OUT;
      S_SHDN:  if (!shdn_more) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
    if (reinit) begin
      state_nxt = S_INIT;
    end
  end

  // Datapath, memory and ALU controls
  always_comb begin
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    sh_nxt         = sh_r;
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    need_nxt       = need_r;
    rest_nxt       = rest_r;
    acc_nxt        = acc_r;
    nxt_len_nxt    = nxt_len_r;
    nf_nxt         = nf_r;
    ers_nxt        = ers_r;
    seg_nxt        = seg_r;
    prev_nxt       = prev_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_valid_nxt  = out_valid_r && !rsp.ready;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;
    alu_op         = ALU_ADD;
    alu_a          = '0;
    alu_b          = '0;

    unique case (state_r)
      S_INIT: begin
        mem_we         = 1'b1;
        mem_wdata.free = 1'b1;
        mem_wdata.len  = pool_size;
        mem_wdata.off  = '0;
        count_nxt      = CNT_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          mode_nxt = req.mode;
          need_nxt = LEN_W'(req.request_size);
          addr_nxt = req.block_address;
        end
      end
      S_PREP: begin
        // round up to the 256-byte granule
        alu_a    = need_r;
        alu_b    = GRANULE_ROUND;
        need_nxt = alu_res.res & ~GRANULE_ROUND;
        cur_nxt  = '0;
      end
      S_SCAN: begin
        alu_op    = ALU_SUB;
        alu_a     = is_alloc ? mem_rdata.len : LEN_W'(mem_rdata.off);
        alu_b     = is_alloc ? need_r : LEN_W'(addr_r);
        mem_raddr = cur_r + IDX_W'(1);
        if (scan_hit) begin
          pos_nxt  = cur_r;
          seg_nxt  = mem_rdata;
          rest_nxt = alu_res.res;
          if (!is_alloc && mem_rdata.free) begin
            res_status_nxt = ST_DOUBLE;
            res_addr_nxt   = '0;
          end
        end else if (scan_last) begin
          res_status_nxt = is_alloc ? ST_OOM : ST_UNKNOWN;
          res_addr_nxt   = '0;
        end else begin
          cur_nxt  = cur_r + IDX_W'(1);
          prev_nxt = mem_rdata;
        end
      end
      S_SPLIT: begin
        alu_op         = ALU_SUB;
        alu_a          = rest_r;
        alu_b          = min_split;
        mem_we         = 1'b1;
        mem_waddr      = pos_r;
        mem_wdata.free = 1'b0;
        mem_wdata.len  = split_ok ? need_r : seg_r.len;
        mem_wdata.off  = seg_r.off;
        res_status_nxt = ST_OK;
        res_addr_nxt   = seg_r.off;
      end
      S_OFFS: begin
        alu_a        = LEN_W'(seg_r.off);
        alu_b        = need_r;
        new_nxt.free = 1'b1;
        new_nxt.len  = rest_r;
        new_nxt.off  = alu_res.res[ADDR_W-1:0];
        sh_nxt       = IDX_W'(cnt_w);
        mem_raddr    = IDX_W'(cnt_w - SUM_W'(1));
      end
      S_SHUP: begin
        // move one entry up, read the one below it
        mem_we    = 1'b1;
        mem_waddr = sh_r;
        mem_wdata = mem_rdata;
        mem_raddr = sh_r - IDX_W'(2);
        sh_nxt    = sh_r - IDX_W'(1);
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(pos_w + SUM_W'(1));
        mem_wdata = new_r;
        count_nxt = count_r + CNT_W'(1);
      end
      S_FNEXT: begin
        alu_a       = pf ? prev_r.len : seg_r.len;
        alu_b       = pf ? seg_r.len : '0;
        acc_nxt     = alu_res.res;
        nf_nxt      = ((pos_w + SUM_W'(1)) < cnt_w) && mem_rdata.free;
        nxt_len_nxt = mem_rdata.len;
      end
      S_ADD2: begin
        alu_a          = acc_r;
        alu_b          = nf_r ? nxt_len_r : '0;
        mem_we         = 1'b1;
        mem_waddr      = base;
        mem_wdata.free = 1'b1;
        mem_wdata.len  = alu_res.res;
        mem_wdata.off  = pf ? prev_r.off : seg_r.off;
        ers_nxt        = ers;
        sh_nxt         = IDX_W'(k0);
        mem_raddr      = IDX_W'(src0);
        res_status_nxt = ST_OK;
        res_addr_nxt   = '0;
        if (!(src0 < cnt_w)) begin
          count_nxt = count_r - CNT_W'(ers);
        end
      end
      S_SHDN: begin
        // close the gap left by merged entries
        mem_we    = 1'b1;
        mem_waddr = sh_r;
        mem_wdata = mem_rdata;
        mem_raddr = IDX_W'(SUM_W'(sh_r) + SUM_W'(ers_r) + SUM_W'(1));
        sh_nxt    = sh_r + IDX_W'(1);
        if (!shdn_more) begin
          count_nxt = count_r - CNT_W'(ers_r);
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    pos_r        <= pos_nxt;
    sh_r         <= sh_nxt;
    mode_r       <= mode_nxt;
    addr_r       <= addr_nxt;
    need_r       <= need_nxt;
    rest_r       <= rest_nxt;
    acc_r        <= acc_nxt;
    nxt_len_r    <= nxt_len_nxt;
    nf_r         <= nf_nxt;
    ers_r        <= ers_nxt;
    seg_r        <= seg_nxt;
    prev_r       <= prev_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/first_fit_pool_allocator_core.sv]
// First-fit pool allocator with coalescing: top level.
//
// Usage: requests arrive on in_ch (valid/ready). mode 0 allocates
// request_size bytes, rounded up to 256; mode 1 frees the block that starts
// at block_address. Each request yields one item on out_ch with
// granted_address (zero unless an allocate succeeds) and status (ok, out of
// memory, double free, unknown address).
// Configuration: cfg_we with cfg_index 0 writes pool_size and rebuilds the
// table as one free segment; index 1 writes min_split_remainder.
// Rate: one request at a time. An item's time grows with the segments
// scanned and, for an allocate that inserts an entry or a free that merges
// and shifts the table, with the entries moved; the walk through the
// segment memory goes one entry per cycle.
// Reset: the table rebuild writes entry 0 in the first cycle after reset;
// in_ch.ready rises the cycle after. A pool_size write holds in_ch.ready low
// in its own cycle and in the rebuild cycle that follows.
// Stall: the result sits in an output register; the sequencer holds in its
// result state, not ready for a new request, until out_ch has taken the previous item.
`default_nettype none

module first_fit_pool_allocator_core import ffap_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ffap_req_if.sink              in_ch,
  ffap_rsp_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);

  logic [LEN_W-1:0] pool_size_r;
  logic [LEN_W-1:0] min_split_r;
  logic             reinit;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  seg_t             mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  seg_t             mem_rdata;

  alu_op_t          alu_op;
  logic [LEN_W-1:0] alu_a;
  logic [LEN_W-1:0] alu_b;
  alu_res_t         alu_res;

  // A pool_size write restarts the table in the following cycle.
  assign reinit = cfg_we && (cfg_index == CFG_POOL_SIZE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_SIZE_RST;
      min_split_r <= MIN_SPLIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_SIZE: pool_size_r <= LEN_W'(cfg_data);
        CFG_MIN_SPLIT: min_split_r <= LEN_W'(cfg_data);
        default: ;
      endcase
    end
  end

  ffap_seq #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .reinit    (reinit),
    .pool_size (pool_size_r),
    .min_split (min_split_r),
    .req       (in_ch),
    .rsp       (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .alu_op    (alu_op),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_res   (alu_res)
  );

  // Segment table, one entry per segment in pool order
  ffap_seg_mem #(
    .DEPTH (MAX_SEGMENTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared adder/comparator for rounding, fit and address tests, split test, offsets and merges
  ffap_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_res)
  );

endmodule

`default_nettype wire

[hw/rtl/ffap_checker.sv]
// Port-level assertions for the pool allocator, bound to the top level.
`default_nettype none

module ffap_checker import ffap_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_granted_address,
  input logic [1:0]        out_status
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_granted_address) && $stable(out_status))
    else $error("result changed while stalled");

  // one request in flight: ready drops right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // failures never report an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_granted_address == '0)
    else $error("nonzero address with error status");

endmodule

bind first_fit_pool_allocator_core ffap_checker u_ffap_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_granted_address (out_ch.granted_address),
  .out_status          (out_ch.status)
);

`default_nettype wire

[tb/first_fit_pool_allocator_core_tb.sv]
// Self-checking testbench for the first-fit pool allocator: directed and random requests.
module first_fit_pool_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffap_pkg::*;

  localparam int SEGS = DEF_MAX_SEGMENTS;

  // One response as the checker expects it.
  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           st;
  } grant_t;

  // One row of the opening table. Rows with pinned set carry a hand-typed answer;
  // the rest are checked against the table model below.
  typedef struct {
    mode_t             mode;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    bit                pinned;
    logic [ADDR_W-1:0] exp_addr;
    status_t           exp_st;
  } probe_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  rsp_rdy = 1'b0;

  ffap_req_if req_ch ();
  ffap_rsp_if rsp_ch ();

  assign rsp_ch.ready = rsp_rdy;

  first_fit_pool_allocator_core #(.MAX_SEGMENTS(SEGS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Segment table model: ordered (offset, length, free) entries covering the pool.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] seg_off  [SEGS];
  logic [LEN_W-1:0]  seg_len  [SEGS];
  logic              seg_free [SEGS];
  int                seg_cnt;
  logic [LEN_W-1:0]  pool_bytes;
  logic [LEN_W-1:0]  split_floor;

  grant_t            pending_q [$];   // responses still owed by the block, oldest first
  logic [ADDR_W-1:0] live_q    [$];   // offsets handed out and not yet returned
  int                n_err = 0;
  int                send_idle;       // percent of cycles the request side holds off
  int                recv_idle;       // percent of cycles the response side stalls
  int                rnd_sent = 0;

  // Collapse the table to one free segment spanning the whole pool.
  function automatic void rebuild_table();
    for (int k = 0; k < SEGS; k++) begin
      seg_off[k]  = '0;
      seg_len[k]  = '0;
      seg_free[k] = 1'b0;
    end
    seg_len[0]  = pool_bytes;
    seg_free[0] = 1'b1;
    seg_cnt     = 1;
  endfunction

  // Remove entry pos and close the hole.
  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < seg_cnt; k++) begin
      seg_off[k]  = seg_off[k+1];
      seg_len[k]  = seg_len[k+1];
      seg_free[k] = seg_free[k+1];
    end
    seg_cnt--;
    seg_off[seg_cnt]  = '0;
    seg_len[seg_cnt]  = '0;
    seg_free[seg_cnt] = 1'b0;
  endfunction

  // Open a free entry at pos; the caller has checked that the table has room.
  function automatic void open_free_entry(int pos, logic [ADDR_W-1:0] off,
                                          logic [LEN_W-1:0] len);
    for (int k = seg_cnt; k > pos; k--) begin
      seg_off[k]  = seg_off[k-1];
      seg_len[k]  = seg_len[k-1];
      seg_free[k] = seg_free[k-1];
    end
    seg_off[pos]  = off;
    seg_len[pos]  = len;
    seg_free[pos] = 1'b1;
    seg_cnt++;
  endfunction

  // First fit: round up to 256 bytes, take the first free segment that holds it,
  // and split off the tail only when it exceeds the split floor and a slot is left.
  function automatic grant_t predict_alloc(logic [ADDR_W-1:0] size);
    logic [LEN_W-1:0] need;
    logic [LEN_W-1:0] rest;
    grant_t           g;
    need   = ({1'b0, size} + GRANULE_ROUND) & ~GRANULE_ROUND;
    g.addr = '0;
    g.st   = ST_OOM;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_free[i] && seg_len[i] >= need) begin
        rest        = seg_len[i] - need;
        seg_free[i] = 1'b0;
        g.addr      = seg_off[i];
        g.st        = ST_OK;
        if (rest > split_floor && seg_cnt < SEGS) begin
          seg_len[i] = need;
          open_free_entry(i + 1, seg_off[i] + need[ADDR_W-1:0], rest);
        end
        return g;
      end
    end
    return g;
  endfunction

  // Exact offset match on the first entry in table order, then merge both ways.
  function automatic grant_t predict_free(logic [ADDR_W-1:0] addr);
    grant_t g;
    int     idx;
    g.addr = '0;
    g.st   = ST_UNKNOWN;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_off[i] == addr) begin
        if (seg_free[i]) begin
          g.st = ST_DOUBLE;
          return g;
        end
        seg_free[i] = 1'b1;
        idx = i;
        if (idx > 0 && seg_free[idx-1]) begin
          seg_len[idx-1] = seg_len[idx-1] + seg_len[idx];
          drop_entry(idx);
          idx--;
        end
        if (idx + 1 < seg_cnt && seg_free[idx+1]) begin
          seg_len[idx] = seg_len[idx] + seg_len[idx+1];
          drop_entry(idx + 1);
        end
        g.st = ST_OK;
        return g;
      end
    end
    return g;
  endfunction

  // Uniform-ish value in [0, hi] over the full 64-bit range.
  function automatic logic [63:0] rand_upto(logic [63:0] hi);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r % (hi + 64'd1);
  endfunction

  // Mostly small sizes relative to the pool, with granule edges, zero, the whole
  // pool and a few huge requests mixed in.
  function automatic logic [ADDR_W-1:0] pick_size();
    int          s;
    logic [63:0] r;
    s = $urandom_range(99);
    if (s < 10)      r = 64'd0;
    else if (s < 55) r = rand_upto(64'(pool_bytes >> 6));
    else if (s < 75) begin
      r = 64'($urandom_range(64)) << 8;
      case ($urandom_range(2))
        0:       r = r + 64'd1;
        1:       r = r + 64'd255;
        default: ;
      endcase
    end
    else if (s < 85) r = rand_upto(64'(pool_bytes >> 2));
    else if (s < 89) r = 64'(pool_bytes);
    else if (s < 92) r = 64'(pool_bytes) - 64'd255;
    else             r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  // Build one random request. Most traffic allocates and returns live blocks;
  // the rest is noise: frees of free segments and of random offsets.
  task automatic draw_request(output mode_t m, output logic [ADDR_W-1:0] size,
                              output logic [ADDR_W-1:0] addr);
    int r;
    int j;
    int fi [$];
    r    = $urandom_range(99);
    m    = MODE_ALLOC;
    size = ADDR_W'({$urandom, $urandom});
    addr = ADDR_W'({$urandom, $urandom});
    if (r < 55 || (r < 90 && live_q.size() == 0)) begin
      size = pick_size();
    end else if (r < 90) begin
      m    = MODE_FREE;
      j    = $urandom_range(live_q.size() - 1);
      addr = live_q[j];
      live_q.delete(j);
    end else begin
      m = MODE_FREE;
      for (int k = 0; k < seg_cnt; k++)
        if (seg_free[k]) fi = {fi, k};
      if ($urandom_range(1) == 0 && fi.size() > 0)
        addr = seg_off[fi[$urandom_range(fi.size() - 1)]];
    end
  endtask

  // Offer one item on the request channel and book its expected response once
  // the block takes it. Valid stays high after the handshake so that a
  // back-to-back item never lowers and raises it in the same step.
  task automatic push_request(mode_t m, logic [ADDR_W-1:0] size, logic [ADDR_W-1:0] addr,
                              bit pinned, grant_t want);
    int     gap;
    grant_t g;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= m;
    req_ch.request_size  <= size;
    req_ch.block_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    if (m == MODE_ALLOC) begin
      g = predict_alloc(size);
      if (g.st == ST_OK) live_q = {live_q, g.addr};
    end else begin
      g = predict_free(addr);
    end
    if (pinned) pending_q = {pending_q, want};
    else        pending_q = {pending_q, g};
  endtask

  // Drop valid and wait until every owed response is back, then let the clock run
  // on so the sequencer is back in idle before a register write.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers while idle; a pool_size write rebuilds the table.
  task automatic apply_setting(logic [LEN_W-1:0] pool, logic [LEN_W-1:0] split);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POOL_SIZE;
    cfg_data  <= pool;
    @(posedge clk);
    cfg_index <= CFG_MIN_SPLIT;
    cfg_data  <= split;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pool_bytes  = pool;
    split_floor = split;
    rebuild_table();
    live_q.delete();
  endtask

  // One random phase under a given setting. Idling follows the overall count:
  // slow receiver first, then slow sender, then full speed.
  task automatic run_phase(logic [LEN_W-1:0] pool, logic [LEN_W-1:0] split, int count);
    mode_t             m;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    grant_t            none;
    none.addr = '0;
    none.st   = ST_OK;
    apply_setting(pool, split);
    repeat (count) begin
      if (rnd_sent < 500) begin
        send_idle = 31;
        recv_idle = 61;
      end else if (rnd_sent < 1000) begin
        send_idle = 61;
        recv_idle = 31;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      draw_request(m, size, addr);
      push_request(m, size, addr, 1'b0, none);
      rnd_sent++;
    end
  endtask

  // Opening table, run at the reset setting (1 GiB pool, split floor 1024).
  probe_t opening_rows [21] = '{
    // zero-size on a fresh pool: zero-length used entry at 0, tail split off
    '{MODE_ALLOC, 36'd0,           36'd0,           1'b1, 36'd0, ST_OK},
    // largest request can never fit
    '{MODE_ALLOC, 36'hF_FFFF_FFFF, 36'd0,           1'b1, 36'd0, ST_OOM},
    // largest offset starts no segment
    '{MODE_FREE,  36'd0,           36'hF_FFFF_FFFF, 1'b1, 36'd0, ST_UNKNOWN},
    '{MODE_ALLOC, 36'd1,           36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_ALLOC, 36'd255,         36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_ALLOC, 36'd256,         36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_ALLOC, 36'd257,         36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_ALLOC, 36'd1024,        36'd0,           1'b0, 36'd0, ST_OK},
    // two entries share offset 0: first in table order wins
    '{MODE_FREE,  36'd0,           36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_FREE,  36'd0,           36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_FREE,  36'd0,           36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_FREE,  36'd256,         36'h0_0000_0100, 1'b0, 36'd0, ST_OK},
    '{MODE_FREE,  36'd0,           36'h0_0000_0100, 1'b0, 36'd0, ST_OK},
    '{MODE_ALLOC, 36'h0_4000_0000, 36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_ALLOC, 36'd0,           36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_FREE,  36'd0,           36'h0_0000_0500, 1'b0, 36'd0, ST_OK},
    '{MODE_ALLOC, 36'd1073741569,  36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_FREE,  36'd0,           36'h8_0000_0000, 1'b0, 36'd0, ST_OK},
    '{MODE_FREE,  36'd0,           36'h0_0000_0300, 1'b0, 36'd0, ST_OK},
    '{MODE_ALLOC, 36'd768,         36'd0,           1'b0, 36'd0, ST_OK},
    '{MODE_FREE,  36'd0,           36'h7_FFFF_FF00, 1'b0, 36'd0, ST_OK}
  };

  // Response side: stall at random and check every accepted item in order.
  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) rsp_rdy <= 1'b0;
    else        rsp_rdy <= ($urandom_range(99) >= recv_idle);
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: response with none owed: addr=%h status=%0d",
                 $time, rsp_ch.granted_address, rsp_ch.status);
        n_err++;
      end else begin
        want = pending_q.pop_front();
        if (rsp_ch.granted_address !== want.addr) begin
          $display("%0t: granted_address expected %h actual %h",
                   $time, want.addr, rsp_ch.granted_address);
          n_err++;
        end
        if (rsp_ch.status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, rsp_ch.status);
          n_err++;
        end
      end
    end
  end

  // Main sequence: reset, opening table, then random phases over several settings.
  initial begin
    grant_t want;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_POOL_SIZE;
    cfg_data             <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.mode          <= MODE_ALLOC;
    req_ch.request_size  <= '0;
    req_ch.block_address <= '0;
    send_idle   = 31;
    recv_idle   = 61;
    pool_bytes  = POOL_SIZE_RST;
    split_floor = MIN_SPLIT_RST;
    rebuild_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) begin
      want.addr = opening_rows[i].exp_addr;
      want.st   = opening_rows[i].exp_st;
      push_request(opening_rows[i].mode, opening_rows[i].size, opening_rows[i].addr,
                   opening_rows[i].pinned, want);
    end

    // largest pool, split on any leftover
    run_phase(37'h10_0000_0000, 37'd0, 300);
    // small pool with eager splitting: drives the table to full
    run_phase(37'd65536, 37'd0, 300);
    // random pool, split floor at its top: blocks go out whole
    run_phase(37'(rand_upto(64'h10_0000_0000)), 37'h10_0000_0000, 300);
    // 1 MiB pool with a random split floor
    run_phase(37'd1048576, 37'(rand_upto(64'd8192)), 300);
    // empty pool: only zero-size requests succeed
    run_phase(37'd0, 37'd1024, 40);
    // back to the reset setting
    run_phase(POOL_SIZE_RST, MIN_SPLIT_RST, 260);

    settle();
    repeat (200) @(posedge clk);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("first_fit_pool_allocator_core test passed");
    end else begin
      $display("first_fit_pool_allocator_core test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("first_fit_pool_allocator_core test failed");
    $finish;
  end

endmodule
